@@ hdl/smac_pkg.sv @@
// Shared types, widths and constants for the sliding mode attitude controller.
// No dependencies; every other file of the block imports this package.
package smac_pkg;

   // Field widths.
   localparam int IN_W      = 16;
   localparam int DT_W      = 20;
   localparam int DTC_W     = 15;
   localparam int INERTIA_W = 20;
   localparam int GAIN_W    = 24;
   localparam int POWER_W   = 31;
   localparam int SUM_W     = 56;
   localparam int NUM_W     = 56;
   localparam int MUL_W     = 32;
   localparam int TIME_W    = 20;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   // Defaults for the top level parameters.
   localparam int FRAC_BITS_DEF = 10;
   localparam int WINDOW_US_DEF = 500000;

   // pi with 30 fractional bits; shifted down to the working format.
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic [DTC_W-1:0] DT_MIN = DTC_W'(125);
   localparam logic [DTC_W-1:0] DT_MAX = DTC_W'(20000);

   localparam logic signed [IN_W-1:0] DRIVE_MAX = 16'sh7FFF;
   localparam logic signed [IN_W-1:0] DRIVE_MIN = 16'sh8000;

   // Register reset values.
   localparam logic [INERTIA_W-1:0] INERTIA_ROLL_RST  = INERTIA_W'(20000);
   localparam logic [INERTIA_W-1:0] INERTIA_PITCH_RST = INERTIA_W'(20000);
   localparam logic [INERTIA_W-1:0] INERTIA_YAW_RST   = INERTIA_W'(40000);
   localparam logic [GAIN_W-1:0]    TORQUE_GAIN_RST   = GAIN_W'(250000);

   // Register indexes (word addresses).
   localparam logic [1:0] REG_INERTIA_ROLL  = 2'd0;
   localparam logic [1:0] REG_INERTIA_PITCH = 2'd1;
   localparam logic [1:0] REG_INERTIA_YAW   = 2'd2;
   localparam logic [1:0] REG_TORQUE_GAIN   = 2'd3;

endpackage

@@ hdl/smac_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on smac_pkg for the operand width.
module smac_mul (
   input  logic                                 clock,
   input  logic signed [smac_pkg::MUL_W-1:0]    op_a,
   input  logic signed [smac_pkg::MUL_W-1:0]    op_b,
   output logic signed [2*smac_pkg::MUL_W-1:0]  product
);
   import smac_pkg::*;

   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [2*MUL_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

@@ hdl/smac_div.sv @@
// Restoring divider producing one quotient bit per cycle.
// Depends on smac_pkg for default widths.
module smac_div #(
   parameter int DIVD_W = smac_pkg::SUM_W,
   parameter int DVS_W  = smac_pkg::GAIN_W + smac_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);
   import smac_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W+1:0]  diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == '0) |=> done_ff)
      else $error("divider missed its done pulse");

endmodule

@@ hdl/sliding_mode_attitude_control.sv @@
// Sliding mode attitude controller with a windowed control power monitor.
// The shared divider yields 56 quotient bits. When a power window closes,
// four power divisions follow; with zero gain the axis divisions are skipped.
// The next transaction waits until the sequencer is idle; a held result stalls it.
// Reset (synchronous, active high) restores the register defaults and clears sums.
// Depends on smac_pkg, smac_mul and smac_div.
module sliding_mode_attitude_control #(
   parameter int FRAC_BITS = smac_pkg::FRAC_BITS_DEF,
   parameter int WINDOW_US = smac_pkg::WINDOW_US_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Input channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [smac_pkg::IN_W-1:0]        req_roll_angle,
   input  logic signed [smac_pkg::IN_W-1:0]        req_pitch_angle,
   input  logic signed [smac_pkg::IN_W-1:0]        req_yaw_angle,
   input  logic signed [smac_pkg::IN_W-1:0]        req_roll_target,
   input  logic signed [smac_pkg::IN_W-1:0]        req_pitch_target,
   input  logic signed [smac_pkg::IN_W-1:0]        req_yaw_target,
   input  logic signed [smac_pkg::IN_W-1:0]        req_roll_rate,
   input  logic signed [smac_pkg::IN_W-1:0]        req_pitch_rate,
   input  logic signed [smac_pkg::IN_W-1:0]        req_yaw_rate,
   input  logic signed [smac_pkg::IN_W-1:0]        req_thrust_cmd,
   input  logic        [smac_pkg::DT_W-1:0]        req_elapsed_us,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [smac_pkg::IN_W-1:0]        rsp_roll_drive,
   output logic signed [smac_pkg::IN_W-1:0]        rsp_pitch_drive,
   output logic signed [smac_pkg::IN_W-1:0]        rsp_yaw_drive,
   output logic signed [smac_pkg::IN_W-1:0]        rsp_throttle_drive,
   output logic                                    rsp_power_ready,
   output logic        [smac_pkg::POWER_W-1:0]     rsp_roll_power,
   output logic        [smac_pkg::POWER_W-1:0]     rsp_pitch_power,
   output logic        [smac_pkg::POWER_W-1:0]     rsp_yaw_power,
   output logic        [smac_pkg::POWER_W-1:0]     rsp_throttle_power,
   // Configuration port.
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic        [smac_pkg::CSR_AW-1:0]      paddr,
   input  logic        [smac_pkg::CSR_DW-1:0]      pwdata,
   output logic        [smac_pkg::CSR_DW-1:0]      prdata,
   output logic                                    pready
);
   import smac_pkg::*;

   // The divider must hold both the torque gain scaled by the Q format and the
   // window time; the gain side is always the wider one.
   localparam int DVS_W = GAIN_W + FRAC_BITS;
   localparam logic [16:0] PI_FLOOR = 17'(PI_Q30 >> (30 - FRAC_BITS));
   localparam logic signed [17:0] ONE_Q = 18'sd1 <<< FRAC_BITS;
   localparam logic [TIME_W-1:0] WINDOW_LIM = TIME_W'(WINDOW_US);

   // Sequencer state codes.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_AX_M0    = 4'd1;
   localparam logic [3:0] ST_AX_M1    = 4'd2;
   localparam logic [3:0] ST_AX_M2    = 4'd3;
   localparam logic [3:0] ST_AX_M3    = 4'd4;
   localparam logic [3:0] ST_AX_DIV   = 4'd5;
   localparam logic [3:0] ST_EN_M0    = 4'd6;
   localparam logic [3:0] ST_EN_M1    = 4'd7;
   localparam logic [3:0] ST_EN_M2    = 4'd8;
   localparam logic [3:0] ST_WIN      = 4'd9;
   localparam logic [3:0] ST_PW_START = 4'd10;
   localparam logic [3:0] ST_PW_DIV   = 4'd11;
   localparam logic [3:0] ST_OUT      = 4'd12;

   // ------------------------------------------------------------------
   // Configuration registers. Writes complete in the access phase; the
   // port never inserts wait states.
   // ------------------------------------------------------------------
   logic [INERTIA_W-1:0] ixx_ff, iyy_ff, izz_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic                 csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ixx_ff  <= INERTIA_ROLL_RST;
         iyy_ff  <= INERTIA_PITCH_RST;
         izz_ff  <= INERTIA_YAW_RST;
         gain_ff <= TORQUE_GAIN_RST;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_INERTIA_ROLL:  ixx_ff  <= pwdata[INERTIA_W-1:0];
            REG_INERTIA_PITCH: iyy_ff  <= pwdata[INERTIA_W-1:0];
            REG_INERTIA_YAW:   izz_ff  <= pwdata[INERTIA_W-1:0];
            REG_TORQUE_GAIN:   gain_ff <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_INERTIA_ROLL:  prdata = CSR_DW'(ixx_ff);
         REG_INERTIA_PITCH: prdata = CSR_DW'(iyy_ff);
         REG_INERTIA_YAW:   prdata = CSR_DW'(izz_ff);
         REG_TORQUE_GAIN:   prdata = CSR_DW'(gain_ff);
         default:           prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Working registers of the current transaction.
   // ------------------------------------------------------------------
   logic [3:0]                state_ff, state_in;
   logic [1:0]                axis_ff, axis_in;
   logic [1:0]                k_ff, k_in;
   logic signed [IN_W-1:0]    ang_ff [3];
   logic signed [IN_W-1:0]    ang_in [3];
   logic signed [IN_W-1:0]    tgt_ff [3];
   logic signed [IN_W-1:0]    tgt_in [3];
   logic signed [IN_W-1:0]    rate_ff [3];
   logic signed [IN_W-1:0]    rate_in [3];
   logic signed [IN_W-1:0]    drv_ff [4];
   logic signed [IN_W-1:0]    drv_in [4];
   logic [POWER_W-1:0]        pw_ff [4];
   logic [POWER_W-1:0]        pw_in [4];
   logic                      rdy_ff, rdy_in;
   logic [DTC_W-1:0]          dt_ff, dt_in;
   logic signed [NUM_W-1:0]   acc_ff, acc_in;
   logic                      neg_ff, neg_in;
   logic [SUM_W-1:0]          sum_ff [4];
   logic [SUM_W-1:0]          sum_in [4];
   logic [TIME_W-1:0]         time_ff, time_in;

   // Output register; it parts the result channel from the sequencer.
   logic                      out_valid_ff, out_valid_in;
   logic signed [IN_W-1:0]    out_drv_ff [4];
   logic signed [IN_W-1:0]    out_drv_in [4];
   logic [POWER_W-1:0]        out_pw_ff [4];
   logic [POWER_W-1:0]        out_pw_in [4];
   logic                      out_rdy_ff, out_rdy_in;

   // Shared units.
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic                      div_start, div_done;
   logic [SUM_W-1:0]          div_dvd, div_quo;
   logic [DVS_W-1:0]          div_dvs;

   smac_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   smac_div #(
      .DIVD_W (SUM_W),
      .DVS_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------------
   // Per axis operand selection and the sliding surface. The surface is
   // s = rate - (target - angle), and the drive term is -sign(s) - s - rate.
   // ------------------------------------------------------------------
   logic signed [IN_W-1:0]      ang_sel, tgt_sel, rate_sel, r1_sel, r2_sel;
   logic [INERTIA_W-1:0]        inertia_sel;
   logic signed [INERTIA_W:0]   cross_sel;
   logic signed [16:0]          z_c;
   logic signed [17:0]          s_c, sg_c;
   logic signed [18:0]          term_c;
   logic signed [NUM_W-1:0]     num_c;
   logic [NUM_W-1:0]            num_mag;
   logic signed [IN_W-1:0]      sat_c;
   logic [16:0]                 qlo;
   logic [DTC_W-1:0]            dt_clamp;
   logic [TIME_W-1:0]           time_new;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            ang_sel = ang_ff[0]; tgt_sel = tgt_ff[0]; rate_sel = rate_ff[0];
            inertia_sel = ixx_ff;
            cross_sel = $signed({1'b0, iyy_ff}) - $signed({1'b0, izz_ff});
            r1_sel = rate_ff[1]; r2_sel = rate_ff[2];
         end
         2'd1: begin
            ang_sel = ang_ff[1]; tgt_sel = tgt_ff[1]; rate_sel = rate_ff[1];
            inertia_sel = iyy_ff;
            cross_sel = $signed({1'b0, izz_ff}) - $signed({1'b0, ixx_ff});
            r1_sel = rate_ff[0]; r2_sel = rate_ff[2];
         end
         default: begin
            ang_sel = ang_ff[2]; tgt_sel = tgt_ff[2]; rate_sel = rate_ff[2];
            inertia_sel = izz_ff;
            cross_sel = $signed({1'b0, ixx_ff}) - $signed({1'b0, iyy_ff});
            r1_sel = rate_ff[0]; r2_sel = rate_ff[1];
         end
      endcase
      z_c  = 17'(tgt_sel) - 17'(ang_sel);
      s_c  = 18'(rate_sel) - 18'(z_c);
      sg_c = (s_c > 0) ? ONE_Q : ((s_c < 0) ? -ONE_Q : 18'sd0);
      term_c = -19'(sg_c) - 19'(s_c) - 19'(rate_sel);
   end

   // The numerator is complete once the cross product leaves the multiplier.
   assign num_c   = acc_ff - $signed(prod[NUM_W-1:0]);
   assign num_mag = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);

   // The quotient magnitude is truncated toward zero, then the sign goes back
   // on and the result saturates to the 16-bit drive range.
   assign qlo = div_quo[16:0];
   always_comb begin
      if (neg_ff) begin
         sat_c = (div_quo > SUM_W'(32768)) ? DRIVE_MIN : IN_W'(17'd0 - qlo);
      end else begin
         sat_c = (div_quo > SUM_W'(32767)) ? DRIVE_MAX : $signed(div_quo[IN_W-1:0]);
      end
   end

   assign dt_clamp = (req_elapsed_us < DT_W'(DT_MIN)) ? DT_MIN :
                     (req_elapsed_us > DT_W'(DT_MAX)) ? DT_MAX :
                     req_elapsed_us[DTC_W-1:0];
   assign time_new = time_ff + TIME_W'(dt_ff);

   // Multiplier operands by step. The cross term takes the rate product
   // straight from the multiplier output.
   always_comb begin
      unique case (state_ff)
         ST_AX_M0: begin
            mul_a = MUL_W'($signed({1'b0, inertia_sel}));
            mul_b = MUL_W'(term_c);
         end
         ST_AX_M1: begin
            mul_a = MUL_W'(r1_sel);
            mul_b = MUL_W'(r2_sel);
         end
         ST_AX_M2: begin
            mul_a = MUL_W'(cross_sel);
            mul_b = prod[MUL_W-1:0];
         end
         ST_EN_M0: begin
            mul_a = MUL_W'(drv_ff[k_ff]);
            mul_b = MUL_W'(drv_ff[k_ff]);
         end
         ST_EN_M1: begin
            mul_a = prod[MUL_W-1:0];
            mul_b = MUL_W'($signed({1'b0, dt_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer. Three axes go through multiply and, with a nonzero gain, divide,
   // then four energy accumulations, then the window check and, when it closes,
   // four power divisions. The result waits in the output register.
   // ------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      k_in      = k_ff;
      ang_in    = ang_ff;
      tgt_in    = tgt_ff;
      rate_in   = rate_ff;
      drv_in    = drv_ff;
      pw_in     = pw_ff;
      rdy_in    = rdy_ff;
      dt_in     = dt_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      sum_in    = sum_ff;
      time_in   = time_ff;
      div_start = 1'b0;
      div_dvd   = NUM_W'(num_mag);
      div_dvs   = {gain_ff, {FRAC_BITS{1'b0}}};
      out_valid_in = out_valid_ff && rsp_stall;
      out_drv_in   = out_drv_ff;
      out_pw_in    = out_pw_ff;
      out_rdy_in   = out_rdy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ang_in[0]  = req_roll_angle;
               ang_in[1]  = req_pitch_angle;
               ang_in[2]  = req_yaw_angle;
               tgt_in[0]  = ($signed({req_roll_target[15], req_roll_target[15],
                             req_roll_target}) <= $signed({1'b0, PI_FLOOR}))
                             ? req_roll_target : '0;
               tgt_in[1]  = ($signed({req_pitch_target[15], req_pitch_target[15],
                             req_pitch_target}) <= $signed({1'b0, PI_FLOOR}))
                             ? req_pitch_target : '0;
               tgt_in[2]  = ($signed({req_yaw_target[15], req_yaw_target[15],
                             req_yaw_target}) <= $signed({1'b0, PI_FLOOR}))
                             ? req_yaw_target : '0;
               rate_in[0] = req_roll_rate;
               rate_in[1] = req_pitch_rate;
               rate_in[2] = req_yaw_rate;
               drv_in[3]  = req_thrust_cmd;
               dt_in      = dt_clamp;
               axis_in    = 2'd0;
               state_in   = ST_AX_M0;
            end
         end
         ST_AX_M0: state_in = ST_AX_M1;
         ST_AX_M1: begin
            acc_in   = $signed(prod[NUM_W-1:0]) <<< FRAC_BITS;
            state_in = ST_AX_M2;
         end
         ST_AX_M2: state_in = ST_AX_M3;
         ST_AX_M3: begin
            if (gain_ff == '0) begin
               // No gain: the drive goes to the rail matching the numerator sign, or to zero.
               drv_in[axis_ff] = (num_c > 0) ? DRIVE_MAX :
                                 ((num_c < 0) ? DRIVE_MIN : '0);
               if (axis_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_EN_M0;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_AX_M0;
               end
            end else begin
               neg_in    = num_c[NUM_W-1];
               div_start = 1'b1;
               state_in  = ST_AX_DIV;
            end
         end
         ST_AX_DIV: begin
            if (div_done) begin
               drv_in[axis_ff] = sat_c;
               if (axis_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_EN_M0;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_AX_M0;
               end
            end
         end
         ST_EN_M0: state_in = ST_EN_M1;
         ST_EN_M1: state_in = ST_EN_M2;
         ST_EN_M2: begin
            sum_in[k_ff] = sum_ff[k_ff] + prod[SUM_W-1:0];
            if (k_ff == 2'd3) begin
               state_in = ST_WIN;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_EN_M0;
            end
         end
         ST_WIN: begin
            time_in = time_new;
            if (time_new > WINDOW_LIM) begin
               rdy_in   = 1'b1;
               k_in     = 2'd0;
               state_in = ST_PW_START;
            end else begin
               rdy_in   = 1'b0;
               pw_in    = '{default: '0};
               state_in = ST_OUT;
            end
         end
         ST_PW_START: begin
            div_dvd   = sum_ff[k_ff];
            div_dvs   = DVS_W'(time_ff);
            div_start = 1'b1;
            state_in  = ST_PW_DIV;
         end
         ST_PW_DIV: begin
            if (div_done) begin
               pw_in[k_ff]  = div_quo[POWER_W-1:0];
               sum_in[k_ff] = '0;
               if (k_ff == 2'd3) begin
                  time_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_PW_START;
               end
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_drv_in   = drv_ff;
               out_pw_in    = pw_ff;
               out_rdy_in   = rdy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '{default: '0};
         time_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         time_ff      <= time_in;
      end
      axis_ff    <= axis_in;
      k_ff       <= k_in;
      ang_ff     <= ang_in;
      tgt_ff     <= tgt_in;
      rate_ff    <= rate_in;
      drv_ff     <= drv_in;
      pw_ff      <= pw_in;
      rdy_ff     <= rdy_in;
      dt_ff      <= dt_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      out_drv_ff <= out_drv_in;
      out_pw_ff  <= out_pw_in;
      out_rdy_ff <= out_rdy_in;
   end

   // A new transaction is taken only while the sequencer is idle; a result
   // still held in the output register does not block it.
   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_roll_drive     = out_drv_ff[0];
   assign rsp_pitch_drive    = out_drv_ff[1];
   assign rsp_yaw_drive      = out_drv_ff[2];
   assign rsp_throttle_drive = out_drv_ff[3];
   assign rsp_power_ready    = out_rdy_ff;
   assign rsp_roll_power     = out_pw_ff[0];
   assign rsp_pitch_power    = out_pw_ff[1];
   assign rsp_yaw_power      = out_pw_ff[2];
   assign rsp_throttle_power = out_pw_ff[3];

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start the sequencer");
   a_open_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (time_ff <= WINDOW_LIM))
      else $error("window time left above the limit");
   a_open_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_rdy_ff) |-> (out_pw_ff[0] == '0 && out_pw_ff[1] == '0
         && out_pw_ff[2] == '0 && out_pw_ff[3] == '0))
      else $error("power reported while the window is open");

endmodule

@@ dv/tb_sliding_mode_attitude_control.sv @@
// Self-checking testbench for the sliding mode attitude controller.
// Depends on smac_pkg and the sliding_mode_attitude_control RTL.
`timescale 1ns / 100ps

module tb_sliding_mode_attitude_control;
   import smac_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WIN_US = WINDOW_US_DEF;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 700;
   localparam int RANDOM_ITEMS = 1630;

   // One input transaction.
   typedef struct packed {
      logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
      logic signed [15:0] roll_target, pitch_target, yaw_target;
      logic signed [15:0] roll_rate, pitch_rate, yaw_rate;
      logic signed [15:0] thrust_cmd;
      logic [19:0]        elapsed_us;
   } tick_t;

   // One result transaction.
   typedef struct packed {
      logic signed [15:0] roll_drive, pitch_drive, yaw_drive, throttle_drive;
      logic               power_ready;
      logic [30:0]        roll_power, pitch_power, yaw_power, throttle_power;
   } ctrl_out_t;

   // Directed stimulus row; has_out marks rows whose result is typed in by hand.
   typedef struct {
      tick_t     tick;
      bit        has_out;
      ctrl_out_t out;
   } vector_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   tick_t req_tick = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b1;
   ctrl_out_t rsp_out;

   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   always #5 clock = ~clock;

   sliding_mode_attitude_control u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_roll_angle(req_tick.roll_angle), .req_pitch_angle(req_tick.pitch_angle),
      .req_yaw_angle(req_tick.yaw_angle), .req_roll_target(req_tick.roll_target),
      .req_pitch_target(req_tick.pitch_target), .req_yaw_target(req_tick.yaw_target),
      .req_roll_rate(req_tick.roll_rate), .req_pitch_rate(req_tick.pitch_rate),
      .req_yaw_rate(req_tick.yaw_rate), .req_thrust_cmd(req_tick.thrust_cmd),
      .req_elapsed_us(req_tick.elapsed_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_roll_drive(rsp_out.roll_drive), .rsp_pitch_drive(rsp_out.pitch_drive),
      .rsp_yaw_drive(rsp_out.yaw_drive), .rsp_throttle_drive(rsp_out.throttle_drive),
      .rsp_power_ready(rsp_out.power_ready),
      .rsp_roll_power(rsp_out.roll_power), .rsp_pitch_power(rsp_out.pitch_power),
      .rsp_yaw_power(rsp_out.yaw_power), .rsp_throttle_power(rsp_out.throttle_power),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // The predictor keeps its own copy of the registers and the power window.
   logic [19:0] inertia_xx, inertia_yy, inertia_zz;
   logic [23:0] gain_d;
   logic [55:0] energy_acc [4];
   logic [19:0] window_us;

   ctrl_out_t expected_q[$];
   int mismatches = 0;
   int accepted_ticks = 0;
   int checked_results = 0;
   int windows_closed = 0;
   int idle_cycles = 0;
   bit long_hold = 0;     // forces a long receiver hold-off
   bit rsp_enable = 0;    // receiver only runs after reset

   function automatic void restore_defaults();
      inertia_xx = INERTIA_ROLL_RST;
      inertia_yy = INERTIA_PITCH_RST;
      inertia_zz = INERTIA_YAW_RST;
      gain_d = TORQUE_GAIN_RST;
      foreach (energy_acc[i]) energy_acc[i] = '0;
      window_us = '0;
   endfunction

   // Drive of one axis: the sliding surface term scaled by its own inertia,
   // minus the gyroscopic cross term, divided by the gain and saturated (a rail when the gain is zero).
   function automatic logic signed [15:0] axis_torque(
      longint angle, longint target, longint rate, longint inertia,
      longint cross_diff, longint r1, longint r2);
      longint one, pi_floor, err, surf, sgn, num, quo;
      one = longint'(1) << FRAC;
      pi_floor = longint'(PI_Q30 >> (30 - FRAC));
      if (target > pi_floor) target = 0;
      err = target - angle;
      surf = rate - err;
      sgn = (surf > 0) ? one : ((surf < 0) ? -one : 0);
      num = inertia * (-sgn - surf - rate) * one - cross_diff * (r1 * r2);
      if (gain_d == 0)
         return (num > 0) ? DRIVE_MAX : ((num < 0) ? DRIVE_MIN : 16'sd0);
      quo = num / (longint'(gain_d) * one);
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      return 16'(quo);
   endfunction

   function automatic ctrl_out_t control_step(tick_t t);
      ctrl_out_t o;
      longint ixx, iyy, izz, p, q, r;
      longint drv [4];
      logic [19:0] dt;
      logic [63:0] sq;
      ixx = inertia_xx; iyy = inertia_yy; izz = inertia_zz;
      p = t.roll_rate; q = t.pitch_rate; r = t.yaw_rate;
      dt = t.elapsed_us;
      if (dt < 125) dt = 125;
      if (dt > 20000) dt = 20000;
      o = '0;
      drv[0] = axis_torque(t.roll_angle, t.roll_target, p, ixx, iyy - izz, q, r);
      drv[1] = axis_torque(t.pitch_angle, t.pitch_target, q, iyy, izz - ixx, p, r);
      drv[2] = axis_torque(t.yaw_angle, t.yaw_target, r, izz, ixx - iyy, p, q);
      drv[3] = t.thrust_cmd;
      o.roll_drive = 16'(drv[0]);
      o.pitch_drive = 16'(drv[1]);
      o.yaw_drive = 16'(drv[2]);
      o.throttle_drive = 16'(drv[3]);
      for (int i = 0; i < 4; i++) begin
         sq = 64'(drv[i] * drv[i]);
         energy_acc[i] = 56'(energy_acc[i] + sq * dt);
      end
      window_us = window_us + dt;
      if (window_us > WIN_US) begin
         o.power_ready = 1'b1;
         o.roll_power = 31'(64'(energy_acc[0]) / window_us);
         o.pitch_power = 31'(64'(energy_acc[1]) / window_us);
         o.yaw_power = 31'(64'(energy_acc[2]) / window_us);
         o.throttle_power = 31'(64'(energy_acc[3]) / window_us);
         foreach (energy_acc[i]) energy_acc[i] = '0;
         window_us = '0;
      end
      return o;
   endfunction

   function automatic logic signed [15:0] rand_field();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(6434)) - 3217);   // up to just past +-pi
         3: return 16'($urandom_range(64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tick_t rand_tick();
      tick_t t;
      t.roll_angle = rand_field();  t.pitch_angle = rand_field();
      t.yaw_angle = rand_field();   t.roll_target = rand_field();
      t.pitch_target = rand_field(); t.yaw_target = rand_field();
      t.roll_rate = rand_field();   t.pitch_rate = rand_field();
      t.yaw_rate = rand_field();    t.thrust_cmd = rand_field();
      case ($urandom_range(7))
         0: t.elapsed_us = 20'($urandom);
         1: t.elapsed_us = 20'($urandom_range(200));
         default: t.elapsed_us = 20'($urandom_range(21000, 5000));
      endcase
      return t;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles();
      int k;
      k = $urandom_range(99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(3, 1);
      return $urandom_range(150, 20);
   endfunction

   // Compare one accepted result with the oldest expectation.
   task automatic check_result(ctrl_out_t got);
      ctrl_out_t exp_o;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
         return;
      end
      exp_o = expected_q.pop_front();
      checked_results++;
      if (got.power_ready) windows_closed++;
      if (got !== exp_o) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", checked_results);
            $display("  drives exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     exp_o.roll_drive, exp_o.pitch_drive, exp_o.yaw_drive,
                     exp_o.throttle_drive, got.roll_drive, got.pitch_drive,
                     got.yaw_drive, got.throttle_drive);
            $display("  power exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                     exp_o.power_ready, exp_o.roll_power, exp_o.pitch_power,
                     exp_o.yaw_power, exp_o.throttle_power, got.power_ready,
                     got.roll_power, got.pitch_power, got.yaw_power,
                     got.throttle_power);
         end
      end
   endtask

   // Result side: samples at the rising edge, then picks the next stall value.
   // A random stall pattern is replaced by a long hold-off while long_hold is set.
   always @(posedge clock) begin
      if (rsp_enable && rsp_valid && !rsp_stall) check_result(rsp_out);
      if (!rsp_enable || long_hold) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < 25);
   end

   // Watchdog: counts cycles in which neither channel accepts a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog expired");
         $display("sliding_mode_attitude_control verification failed");
         $finish;
      end
   end

   // Offers one transaction and waits until it is accepted; the prediction is
   // made at acceptance so that it sees the registers in force at that time.
   task automatic send_tick(tick_t t, bit has_out, ctrl_out_t typed);
      ctrl_out_t pred;
      req_tick <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = control_step(t);
      if (has_out && pred !== typed) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: typed result differs for %p", t);
      end
      expected_q.push_back(has_out ? typed : pred);
      accepted_ticks++;
   endtask

   task automatic pause_sender(int n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Configuration write: setup cycle, then the access cycle.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      req_valid <= 1'b0;
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_AW'({idx, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_INERTIA_ROLL:  inertia_xx = value[19:0];
         REG_INERTIA_PITCH: inertia_yy = value[19:0];
         REG_INERTIA_YAW:   inertia_zz = value[19:0];
         REG_TORQUE_GAIN:   gain_d = value[23:0];
         default: ;
      endcase
   endtask

   // Waits until all results have arrived and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] ixx, logic [31:0] iyy,
                            logic [31:0] izz, logic [31:0] d);
      drain();
      csr_write(REG_INERTIA_ROLL, ixx);
      csr_write(REG_INERTIA_PITCH, iyy);
      csr_write(REG_INERTIA_YAW, izz);
      csr_write(REG_TORQUE_GAIN, d);
   endtask

   function automatic tick_t make_tick(int a, int tg, int rt, int thr, int dt);
      tick_t t;
      t.roll_angle = 16'(a);  t.pitch_angle = 16'(-a); t.yaw_angle = 16'(a);
      t.roll_target = 16'(tg); t.pitch_target = 16'(tg); t.yaw_target = 16'(-tg);
      t.roll_rate = 16'(rt);   t.pitch_rate = 16'(rt);  t.yaw_rate = 16'(-rt);
      t.thrust_cmd = 16'(thr);
      t.elapsed_us = 20'(dt);
      return t;
   endfunction

   vector_t directed [$];

   initial begin
      vector_t v;
      ctrl_out_t zero_o;
      restore_defaults();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      rsp_enable = 1;
      @(posedge clock);

      // Directed table. An all-zero tick gives zero drives at any setting.
      zero_o = '0;
      v.has_out = 1; v.out = zero_o; v.tick = '0;
      directed.push_back(v);
      v.has_out = 0;
      v.tick = make_tick(0, 0, 0, 32767, 20000);  directed.push_back(v);
      v.tick = make_tick(0, 0, 0, -32768, 0);     directed.push_back(v);
      v.tick = make_tick(100, 3216, 0, 5, 1048575); directed.push_back(v);  // pi edge
      v.tick = make_tick(100, 3217, 0, 5, 124);    directed.push_back(v);   // above pi
      v.tick = make_tick(-32768, 32767, 32767, 1, 125); directed.push_back(v);
      v.tick = make_tick(32767, -32768, -32768, -1, 20001); directed.push_back(v);
      v.tick = make_tick(50, 50, 0, 0, 1000);      directed.push_back(v);   // roll surface zero
      v.tick = make_tick(7, -9, 3, 300, 19999);    directed.push_back(v);
      for (int i = 0; i < 26; i++) begin           // close a power window
         v.tick = make_tick(i * 40, 500, i - 13, i * 1000, 20000);
         directed.push_back(v);
      end
      foreach (directed[i]) send_tick(directed[i].tick, directed[i].has_out,
                                      directed[i].out);

      // Extreme register settings: all zero, then full-scale roll and yaw inertias, then maximum gain.
      write_all(0, 0, 0, 0);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, zero_o);
      write_all(32'hFFFFF, 1, 32'hFFFFF, 1);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, zero_o);
      write_all(1000000, 1000000, 1, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, zero_o);

      // Random phases, each with its own register setting. In the second phase
      // the receiver holds off for a long stretch while the sender keeps offering.
      for (int ph = 0; ph < 5; ph++) begin
         write_all($urandom_range(1000000, 1), $urandom_range(1000000, 1),
                   $urandom_range(1000000, 1),
                   (ph == 3) ? 32'($urandom_range(50)) :
                   32'($urandom_range(10000000, 1)));
         for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
            if (ph == 1 && k == 10) begin
               long_hold = 1;
               fork
                  begin
                     repeat (3000) @(posedge clock);
                     long_hold = 0;
                  end
               join_none
            end
            if (ph != 2 || k > 100) pause_sender(gap_cycles());
            send_tick(rand_tick(), 0, zero_o);
         end
      end

      drain();
      $display("Covered %0d ticks with %0d results checked, %0d power windows closed.",
               accepted_ticks, checked_results, windows_closed);
      $display("Register sweeps included zero gain, zero and full-scale inertias.");
      if (mismatches == 0)
         $display("sliding_mode_attitude_control verification clean");
      else
         $display("sliding_mode_attitude_control verification failed");
      $finish;
   end

endmodule
